@@ rtl/bde_pkg.sv @@
package bde_pkg;

  localparam int DATA_W    = 32;
  localparam int CAP_W     = 11;
  localparam int DEPTH_DEF = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // register map: byte address 4*index
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_CAPACITY = 1'b0;

  // action codes
  localparam logic [1:0] ACT_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] ACT_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] ACT_POP_LEFT   = 2'd2;
  localparam logic [1:0] ACT_POP_RIGHT  = 2'd3;

  // result status codes
  localparam logic [1:0] STS_PUSHED = 2'd0;
  localparam logic [1:0] STS_POPPED = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;
  localparam logic [1:0] STS_EMPTY  = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] pop_data;
  } out_item_t;

  // decoded operation for the current action
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [1:0] status;
  } op_t;

endpackage

@@ rtl/bde_ram.sv @@
module bde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/bde_ptr.sv @@
module bde_ptr #(
  parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [1:0]                action,
  input  logic [bde_pkg::CAP_W-1:0] capacity,
  output bde_pkg::op_t              op,
  output logic [$clog2(DEPTH)-1:0]  addr
);
  import bde_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_inc, head_dec, pos_right, pos_last;
  logic [SW-1:0] sum_right, sum_last;
  logic [KW-1:0] lim;
  logic          full, empty;

  always_comb begin
    // effective capacity is clamped to the physical depth
    lim   = (KW'(capacity) < KW'(DEPTH)) ? KW'(capacity) : KW'(DEPTH);
    full  = KW'(count_r) >= lim;
    empty = (count_r == '0);

    head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;

    // both sums stay below 2*DEPTH when used (sum_last only when not empty), one conditional subtract wraps them
    sum_right = SW'(head_r) + SW'(count_r);
    sum_last  = sum_right - 1'b1;
    pos_right = (sum_right >= SW'(DEPTH)) ? AW'(sum_right - SW'(DEPTH)) : AW'(sum_right);
    pos_last  = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);

    op        = '0;
    addr      = head_r;
    head_nxt  = head_r;
    count_nxt = count_r;

    case (action)
      ACT_PUSH_LEFT: begin
        if (full) begin
          op.status = STS_FULL;
        end else begin
          op.wr     = 1'b1;
          op.status = STS_PUSHED;
          addr      = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_PUSH_RIGHT: begin
        if (full) begin
          op.status = STS_FULL;
        end else begin
          op.wr     = 1'b1;
          op.status = STS_PUSHED;
          addr      = pos_right;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_POP_LEFT: begin
        if (empty) begin
          op.status = STS_EMPTY;
        end else begin
          op.rd     = 1'b1;
          op.status = STS_POPPED;
          addr      = head_r;
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_POP_RIGHT: begin
        if (empty) begin
          op.status = STS_EMPTY;
        end else begin
          op.rd     = 1'b1;
          op.status = STS_POPPED;
          addr      = pos_last;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        op.status = STS_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/bde_outq.sv @@
module bde_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  bde_pkg::out_item_t res_item,
  input  logic               out_stall,
  output logic               out_valid,
  output bde_pkg::out_item_t out_data,
  output logic               skid_full
);
  import bde_pkg::*;

  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;
  logic      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign skid_full = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= res_item;
      end else begin
        out_data_r  <= res_item;
      end
    end else if (res_valid) begin
      skid_data_r <= res_item;
    end
  end

endmodule

@@ rtl/bounded_deque_engine_unit.sv @@
// Results: pushes and refusals are registered in the output stage; a successful pop
//   goes through the synchronous entry RAM read first, and the next action waits for it.
// Throughput: pushes and refusals 1 per cycle while the skid slot is free (out_stall).
// Reset (rst_n low, synchronous): head and count cleared, capacity back to 1024,
//   output register and skid emptied. Entry RAM is not cleared; no entry is read before
//   it is written, so no clearing pass is needed and the block is ready right after reset.
module bounded_deque_engine_unit #(
  parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bde_pkg::in_item_t              in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output bde_pkg::out_item_t             out_data,
  // configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bde_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import bde_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // sequencer: IDLE takes a transfer, READ waits for the RAM data of a pop
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [CAP_W-1:0] capacity_r;
  logic             accept;
  op_t              op;
  logic [AW-1:0]    mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  logic             skid_full;
  logic             res_valid;
  out_item_t        res_item;
  logic             cfg_wr;

  // --- configuration: single capacity register at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_CAPACITY) begin
      cfg_prdata = {{(32 - CAP_W){1'b0}}, capacity_r};
    end
  end

  // --- input side: one action at a time, and only while the skid slot is free,
  // so every accepted action has a place for its result
  assign in_stall = (state_r != ST_IDLE) || skid_full;
  assign accept   = in_valid && !in_stall;

  // pointer unit: head/count, full/empty decision and RAM address
  bde_ptr #(
    .DEPTH (DEPTH)
  ) ptr_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_data.action),
    .capacity (capacity_r),
    .op       (op),
    .addr     (mem_addr)
  );

  // entry store. A pop never shares a cycle with a write, and its read is issued
  // after any earlier push has written, so no forwarding is needed.
  bde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) ram_i (
    .clk   (clk),
    .we    (accept && op.wr),
    .re    (accept && op.rd),
    .addr  (mem_addr),
    .wdata (in_data.push_value),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && op.rd) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --- result: immediate for pushes and refusals, RAM data for a pop
  always_comb begin
    res_valid = 1'b0;
    res_item  = '0;
    if (state_r == ST_READ) begin
      res_valid         = 1'b1;
      res_item.status   = STS_POPPED;
      res_item.pop_data = mem_rdata;
    end else if (accept && !op.rd) begin
      res_valid       = 1'b1;
      res_item.status = op.status;
    end
  end

  bde_outq outq_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_full (skid_full)
  );

endmodule

@@ rtl/bde_chk.sv @@
module bde_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bde_pkg::out_item_t out_data
);
  import bde_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // output comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // only a successful pop carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STS_POPPED) |-> out_data.pop_data == '0)
    else $error("nonzero value on non-pop result");

  // a fresh result follows an input transfer
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_xfer, 1) || $past(in_xfer, 2))
    else $error("result without a recent input transfer");

endmodule

bind bounded_deque_engine_unit bde_chk chk_i (.*);
